// ===== sv/psb_pkg.sv =====
// ---------------------------------------------------------------------------
// psb_pkg
// Shared types, constants and saturation helper for the particle wall bounce.
// ---------------------------------------------------------------------------
package psb_pkg;

   localparam int WORD       = 32;
   localparam int FRAC       = 16;
   localparam int NUM_W      = 48;
   localparam int DEN_W      = 32;
   localparam int DIV_STAGES = NUM_W;
   localparam int FIFO_DEPTH = 4;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   localparam logic [1:0] MODE_NOSLIP = 2'd1;
   localparam logic [1:0] MODE_SLIP   = 2'd2;

   localparam logic [2:0] REG_WALL_MODE  = 3'd0;
   localparam logic [2:0] REG_TIME_STEP  = 3'd1;
   localparam logic [2:0] REG_TOP_HEIGHT = 3'd2;
   localparam logic [2:0] REG_WALL_VEL_X = 3'd3;
   localparam logic [2:0] REG_WALL_VEL_Y = 3'd4;

   typedef struct packed {
      logic [2:0][WORD-1:0] p;
      logic [2:0][WORD-1:0] v;
      logic [1:0]           mode;
      logic                 push;
   } part_type;

   function automatic logic [WORD-1:0] sat_word(input logic signed [63:0] x);
      logic [WORD-1:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[WORD-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] sext(input logic [WORD-1:0] x);
      return $signed({{(64-WORD){x[WORD-1]}}, x});
   endfunction

   function automatic logic walls_on(input logic [1:0] mode);
      return (mode == MODE_NOSLIP) || (mode == MODE_SLIP);
   endfunction

endpackage

// ===== sv/particle_stream_wall_bounce.sv =====
// ---------------------------------------------------------------------------
// particle_stream_wall_bounce
// Streams one particle by the time step and bounces it off top and bottom walls.
// ---------------------------------------------------------------------------
// Takes one particle per clock while req_tready is high and returns one particle
// per clock while rsp_tready is high, in order. Path: two streaming stages, the
// queue, then two pipelined dividers (one quotient bit per stage) for the top and
// bottom overshoot times with their multiply and add stages. The queue holds
// four particles, counting those still in the two streaming stages, so the
// input stops when the queue fills while a result waits on rsp_tready;
// the back end stalls as a whole only on the output register.
// Configuration registers: 0 wall_mode, 1 time_step, 2 top_height,
// 3 wall_vel_x, 4 wall_vel_y; write them only while no transaction is in flight.
module particle_stream_wall_bounce (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   input  logic [191:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
   output logic [191:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata
);
   import psb_pkg::*;

   logic [1:0]        wall_mode_ff;
   logic [19:0]       time_step_ff;
   logic [30:0]       top_height_ff;
   logic [WORD-1:0]   wall_vel_x_ff;
   logic [WORD-1:0]   wall_vel_y_ff;

   logic [2:0][WORD-1:0] in_p;
   logic [2:0][WORD-1:0] in_v;
   logic              front_valid;
   part_type          front_item;
   logic [1:0]        inflight;
   part_type          head_item;
   logic              fifo_empty;
   logic [CNT_W-1:0]  fifo_count;
   logic              pop;
   part_type          rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_mode_ff  <= '0;
         time_step_ff  <= 20'd65536;
         top_height_ff <= '0;
         wall_vel_x_ff <= '0;
         wall_vel_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WALL_MODE:  wall_mode_ff  <= csr_wdata[1:0];
            REG_TIME_STEP:  time_step_ff  <= csr_wdata[19:0];
            REG_TOP_HEIGHT: top_height_ff <= csr_wdata[30:0];
            REG_WALL_VEL_X: wall_vel_x_ff <= csr_wdata;
            REG_WALL_VEL_Y: wall_vel_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_p[i] = req_tdata[i*WORD +: WORD];
         in_v[i] = req_tdata[(i+3)*WORD +: WORD];
      end
   end

   // room for everything already in the front stages
   assign req_tready = (fifo_count + CNT_W'(inflight)) < CNT_W'(FIFO_DEPTH);

   psb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && req_tready),
      .in_p      (in_p),
      .in_v      (in_v),
      .time_step (time_step_ff),
      .wall_mode (wall_mode_ff),
      .out_valid (front_valid),
      .out_item  (front_item),
      .inflight  (inflight)
   );

   psb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (fifo_empty),
      .count     (fifo_count)
   );

   psb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!fifo_empty),
      .head_item  (head_item),
      .pop        (pop),
      .top_height (top_height_ff),
      .wall_vel_x (wall_vel_x_ff),
      .wall_vel_y (wall_vel_y_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (rsp_item)
   );

   assign rsp_tdata = {rsp_item.v[2], rsp_item.v[1], rsp_item.v[0],
                       rsp_item.p[2], rsp_item.p[1], rsp_item.p[0]};

endmodule

// ===== sv/psb_front.sv =====
// ---------------------------------------------------------------------------
// psb_front
// Streaming stage: p + floor(v * time_step), two pipeline stages, no stall.
// ---------------------------------------------------------------------------
module psb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [2:0][psb_pkg::WORD-1:0]      in_p,
   input  logic [2:0][psb_pkg::WORD-1:0]      in_v,
   input  logic [19:0]                        time_step,
   input  logic [1:0]                         wall_mode,
   output logic                               out_valid,
   output psb_pkg::part_type                  out_item,
   output logic [1:0]                         inflight
);
   import psb_pkg::*;

   logic                       v1_ff;
   logic [2:0][WORD-1:0]       p1_ff;
   logic [2:0][WORD-1:0]       vel1_ff;
   logic signed [52:0]         prod_ff [3];
   logic [1:0]                 mode1_ff;
   logic                       v2_ff;
   part_type                   item_ff;
   part_type                   item_in;

   always_comb begin
      item_in      = '0;
      item_in.v    = vel1_ff;
      item_in.mode = mode1_ff;
      item_in.push = 1'b0;
      for (int i = 0; i < 3; i++) begin
         item_in.p[i] = sat_word(sext(p1_ff[i]) +
                                 $signed({{27{prod_ff[i][52]}}, prod_ff[i][52:16]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      p1_ff    <= in_p;
      vel1_ff  <= in_v;
      mode1_ff <= wall_mode;
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= $signed({{21{in_v[i][WORD-1]}}, in_v[i]}) *
                       $signed({33'd0, time_step});
      end
      item_ff <= item_in;
   end

   assign out_valid = v2_ff;
   assign out_item  = item_ff;
   assign inflight  = 2'(v1_ff) + 2'(v2_ff);

endmodule

// ===== sv/psb_fifo.sv =====
// ---------------------------------------------------------------------------
// psb_fifo
// Short queue between the streaming front and the wall back end.
// ---------------------------------------------------------------------------
module psb_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  psb_pkg::part_type           push_item,
   input  logic                        pop,
   output psb_pkg::part_type           head_item,
   output logic                        empty,
   output logic [psb_pkg::CNT_W-1:0]   count
);
   import psb_pkg::*;

   part_type             mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ff;
   logic [PTR_W-1:0]     rd_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(do_pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign head_item = mem_ff[rd_ff];
   assign empty     = (cnt_ff == '0);
   assign count     = cnt_ff;

endmodule

// ===== sv/psb_div.sv =====
// ---------------------------------------------------------------------------
// psb_div
// Pipelined restoring divider, one quotient bit per stage, signed and
// saturated quotient; carries the particle alongside.
// ---------------------------------------------------------------------------
module psb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [psb_pkg::NUM_W-1:0]    in_num,
   input  logic [psb_pkg::DEN_W-1:0]    in_den,
   input  logic                         in_neg,
   input  psb_pkg::part_type            in_item,
   output logic                         out_valid,
   output logic [psb_pkg::WORD-1:0]     out_quo,
   output psb_pkg::part_type            out_item
);
   import psb_pkg::*;

   logic              vld_ff  [DIV_STAGES];
   logic [DEN_W-1:0]  rem_ff  [DIV_STAGES];
   logic [NUM_W-1:0]  nq_ff   [DIV_STAGES];
   logic [DEN_W-1:0]  den_ff  [DIV_STAGES];
   logic              neg_ff  [DIV_STAGES];
   part_type          item_ff [DIV_STAGES];

   logic              vld_o_ff;
   logic [WORD-1:0]   quo_ff;
   part_type          item_o_ff;
   logic [WORD-1:0]   quo_in;
   logic [NUM_W-1:0]  q_last;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic              src_vld;
      logic [DEN_W-1:0]  src_rem;
      logic [NUM_W-1:0]  src_nq;
      logic [DEN_W-1:0]  src_den;
      logic              src_neg;
      part_type          src_item;
      logic [DEN_W:0]    shifted;
      logic [DEN_W:0]    diff;
      logic              ge;

      if (s == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rem  = '0;
         assign src_nq   = in_num;
         assign src_den  = in_den;
         assign src_neg  = in_neg;
         assign src_item = in_item;
      end else begin : g_next
         assign src_vld  = vld_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_nq   = nq_ff[s-1];
         assign src_den  = den_ff[s-1];
         assign src_neg  = neg_ff[s-1];
         assign src_item = item_ff[s-1];
      end

      assign shifted = {src_rem, src_nq[NUM_W-1]};
      assign diff    = shifted - {1'b0, src_den};
      assign ge      = (shifted >= {1'b0, src_den});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld;
         end
         if (en) begin
            rem_ff[s]  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            nq_ff[s]   <= {src_nq[NUM_W-2:0], ge};
            den_ff[s]  <= src_den;
            neg_ff[s]  <= src_neg;
            item_ff[s] <= src_item;
         end
      end
   end

   assign q_last = nq_ff[DIV_STAGES-1];

   // zero divisor gives zero time, otherwise truncate toward zero and saturate
   always_comb begin
      priority if (den_ff[DIV_STAGES-1] == '0) begin
         quo_in = '0;
      end else if (neg_ff[DIV_STAGES-1]) begin
         quo_in = (q_last > 48'd2147483648) ? 32'h8000_0000 : WORD'(-q_last);
      end else begin
         quo_in = (q_last > 48'd2147483647) ? 32'h7FFF_FFFF : q_last[WORD-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_o_ff <= 1'b0;
      end else if (en) begin
         vld_o_ff <= vld_ff[DIV_STAGES-1];
      end
      if (en) begin
         quo_ff    <= quo_in;
         item_o_ff <= item_ff[DIV_STAGES-1];
      end
   end

   assign out_valid = vld_o_ff;
   assign out_quo   = quo_ff;
   assign out_item  = item_o_ff;

endmodule

// ===== sv/psb_back.sv =====
// ---------------------------------------------------------------------------
// psb_back
// Wall handling: top reflection (overshoot time for no-slip), then bottom
// bounce-back, each via its own pipelined divider; output register at end.
// ---------------------------------------------------------------------------
module psb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  psb_pkg::part_type            head_item,
   output logic                         pop,
   input  logic [30:0]                  top_height,
   input  logic [psb_pkg::WORD-1:0]     wall_vel_x,
   input  logic [psb_pkg::WORD-1:0]     wall_vel_y,
   output logic                         out_valid,
   input  logic                         out_ready,
   output psb_pkg::part_type            out_item
);
   import psb_pkg::*;

   logic              adv;

   // top wall
   part_type          t0_item;
   logic [NUM_W-1:0]  t0_num;
   logic [DEN_W-1:0]  t0_den;
   logic              t0_neg;
   logic              hit_top;
   logic signed [63:0] d_top;

   logic              td_valid;
   logic [WORD-1:0]   td_quo;
   part_type          td_item;

   logic              t2_vld_ff;
   logic [WORD-1:0]   t2_t_ff;
   logic [2:0][WORD-1:0] t2_wd_ff;
   part_type          t2_item_ff;

   logic              t3_vld_ff;
   logic signed [63:0] t3_m_ff [3];
   part_type          t3_item_ff;

   logic              t4_vld_ff;
   part_type          t4_item_ff;
   part_type          t4_item_in;

   // bottom wall
   part_type          b0_item;
   logic [NUM_W-1:0]  b0_num;
   logic [DEN_W-1:0]  b0_den;
   logic              b0_neg;
   logic [WORD-1:0]   neg_p2;

   logic              bd_valid;
   logic [WORD-1:0]   bd_quo;
   part_type          bd_item;

   logic              b3_vld_ff;
   logic signed [63:0] b3_m_ff [3];
   part_type          b3_item_ff;

   logic              out_vld_ff;
   part_type          out_item_ff;
   part_type          out_item_in;

   assign adv = !out_vld_ff || out_ready;
   assign pop = adv && head_valid;

   always_comb begin
      t0_item      = head_item;
      t0_item.push = 1'b0;
      hit_top      = walls_on(head_item.mode) &&
                     ($signed({head_item.p[2][WORD-1], head_item.p[2]}) >
                      $signed({2'b00, top_height}));
      d_top        = sext(head_item.p[2]) - $signed({33'd0, top_height});
      t0_num       = {d_top[31:0], 16'd0};
      t0_den       = head_item.v[2][WORD-1] ? DEN_W'(-head_item.v[2]) : head_item.v[2];
      t0_neg       = head_item.v[2][WORD-1];
      if (hit_top) begin
         t0_item.v[2] = sat_word(-sext(head_item.v[2]));
         if (head_item.mode == MODE_NOSLIP) begin
            t0_item.v[0] = sat_word((sext(wall_vel_x) <<< 1) - sext(head_item.v[0]));
            t0_item.v[1] = sat_word((sext(wall_vel_y) <<< 1) - sext(head_item.v[1]));
            t0_item.push = 1'b1;
         end else begin
            t0_item.p[2] = sat_word($signed({32'd0, top_height, 1'b0}) -
                                    sext(head_item.p[2]));
         end
      end
   end

   psb_div u_div_top (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (head_valid),
      .in_num    (t0_num),
      .in_den    (t0_den),
      .in_neg    (t0_neg),
      .in_item   (t0_item),
      .out_valid (td_valid),
      .out_quo   (td_quo),
      .out_item  (td_item)
   );

   always_comb begin
      t4_item_in      = t3_item_ff;
      t4_item_in.push = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (t3_item_ff.push) begin
            t4_item_in.p[i] = sat_word(sext(t3_item_ff.p[i]) + (t3_m_ff[i] >>> (FRAC - 1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_vld_ff <= 1'b0;
         t3_vld_ff <= 1'b0;
         t4_vld_ff <= 1'b0;
      end else if (adv) begin
         t2_vld_ff <= td_valid;
         t3_vld_ff <= t2_vld_ff;
         t4_vld_ff <= t3_vld_ff;
      end
      if (adv) begin
         t2_t_ff     <= td_quo;
         t2_wd_ff[0] <= sat_word(sext(td_item.v[0]) - sext(wall_vel_x));
         t2_wd_ff[1] <= sat_word(sext(td_item.v[1]) - sext(wall_vel_y));
         t2_wd_ff[2] <= td_item.v[2];
         t2_item_ff  <= td_item;
         for (int i = 0; i < 3; i++) begin
            t3_m_ff[i] <= $signed(t2_t_ff) * $signed(t2_wd_ff[i]);
         end
         t3_item_ff <= t2_item_ff;
         t4_item_ff <= t4_item_in;
      end
   end

   // bottom check sees z and vz after any top reflection
   always_comb begin
      b0_item      = t4_item_ff;
      b0_item.push = 1'b0;
      neg_p2       = WORD'(-t4_item_ff.p[2]);
      b0_num       = {neg_p2, 16'd0};
      b0_den       = t4_item_ff.v[2][WORD-1] ? DEN_W'(-t4_item_ff.v[2]) : t4_item_ff.v[2];
      b0_neg       = !t4_item_ff.v[2][WORD-1];
      if (walls_on(t4_item_ff.mode) && t4_item_ff.p[2][WORD-1]) begin
         b0_item.push = 1'b1;
         for (int i = 0; i < 3; i++) begin
            b0_item.v[i] = sat_word(-sext(t4_item_ff.v[i]));
         end
      end
   end

   psb_div u_div_bot (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (t4_vld_ff),
      .in_num    (b0_num),
      .in_den    (b0_den),
      .in_neg    (b0_neg),
      .in_item   (b0_item),
      .out_valid (bd_valid),
      .out_quo   (bd_quo),
      .out_item  (bd_item)
   );

   always_comb begin
      out_item_in      = b3_item_ff;
      out_item_in.push = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (b3_item_ff.push) begin
            out_item_in.p[i] = sat_word(sext(b3_item_ff.p[i]) + (b3_m_ff[i] >>> (FRAC - 1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         b3_vld_ff  <= bd_valid;
         out_vld_ff <= b3_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            b3_m_ff[i] <= $signed(bd_quo) * $signed(bd_item.v[i]);
         end
         b3_item_ff  <= bd_item;
         out_item_ff <= out_item_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_item  = out_item_ff;

endmodule

// ===== tb/tb_particle_stream_wall_bounce.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_particle_stream_wall_bounce
// Self-checking bench for the particle streaming and wall bounce block: a
// directed table, then random particles over several register settings, with
// bursty input and stalling output, checked by predictor or stored results.
// ---------------------------------------------------------------------------
module tb_particle_stream_wall_bounce;
   import psb_pkg::*;

   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [2:0] REG_LAST    = REG_WALL_VEL_Y;
   localparam int IDLE_WAIT  = 150;
   localparam int WDOG_LIMIT = 5000;
   localparam int PHASES     = 9;
   localparam int PER_PHASE  = 170;

   typedef struct {
      logic [191:0] particle;
      bit           fixed;
      logic [191:0] result;
   } stim_type;

   typedef struct {
      logic [1:0]   mode;
      logic [191:0] particle;
      bit           fixed;
      logic [191:0] result;
   } row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [191:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [191:0]  rsp_tdata;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   particle_stream_wall_bounce dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // configuration as the block should hold it
   logic [1:0]    cfg_mode = MODE_OFF;
   longint        cfg_step = 65536;
   longint        cfg_top = 0;
   longint        cfg_wvx = 0;
   longint        cfg_wvy = 0;

   stim_type      pending_q[$];
   logic [191:0]  expected_q[$];
   stim_type      offered;
   int            fails = 0;
   int            results_seen = 0;

   function automatic longint clamp(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint overshoot(longint num, longint den);
      if (den == 0) return 0;
      return clamp((num * 65536) / den);
   endfunction

   function automatic longint displace(longint p, longint t, longint w);
      return clamp(p + ((t * w) >>> (FRAC - 1)));
   endfunction

   function automatic logic [191:0] predict_bounce(logic [191:0] d);
      longint p[3], v[3];
      longint t2;
      logic [191:0] r;
      for (int i = 0; i < 3; i++) begin
         p[i] = longint'($signed(d[32*i +: 32]));
         v[i] = longint'($signed(d[32*(3+i) +: 32]));
         p[i] = clamp(p[i] + ((v[i] * cfg_step) >>> FRAC));
      end
      if (cfg_mode == MODE_NOSLIP || cfg_mode == MODE_SLIP) begin
         if (p[2] > cfg_top) begin
            if (cfg_mode == MODE_NOSLIP) begin
               t2 = overshoot(p[2] - cfg_top, v[2]);
               v[0] = clamp(2 * cfg_wvx - v[0]);
               v[1] = clamp(2 * cfg_wvy - v[1]);
               v[2] = clamp(-v[2]);
               p[0] = displace(p[0], t2, clamp(v[0] - cfg_wvx));
               p[1] = displace(p[1], t2, clamp(v[1] - cfg_wvy));
               p[2] = displace(p[2], t2, v[2]);
            end else begin
               v[2] = clamp(-v[2]);
               p[2] = clamp(2 * cfg_top - p[2]);
            end
         end
         // bottom check sees z and vz after the top reflection
         if (p[2] < 0) begin
            t2 = overshoot(p[2], v[2]);
            for (int i = 0; i < 3; i++) begin
               v[i] = clamp(-v[i]);
               p[i] = displace(p[i], t2, v[i]);
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         r[32*i +: 32] = p[i][31:0];
         r[32*(3+i) +: 32] = v[i][31:0];
      end
      return r;
   endfunction

   function automatic logic [191:0] pack6(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      return {vz, vy, vx, pz, py, px};
   endfunction

   // sender: bursts with gaps, holds an item until it is taken
   int burst_left = 5;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_q.insert(expected_q.size(),
                              offered.fixed ? offered.result
                                            : predict_bounce(offered.particle));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               offered = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= offered.particle;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern in stretches, one long hold-off
   int stretch_left = 0;
   int ready_pct = 100;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= 300) begin
            hold_done = 1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            if (stretch_left <= 0) begin
               stretch_left = $urandom_range(10, 80);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 50;
                  2: ready_pct = 25;
                  default: ready_pct = 85;
               endcase
            end
            stretch_left--;
            rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [191:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
            fails++;
         end else begin
            want = expected_q.pop_front();
            for (int f = 0; f < 6; f++) begin
               if (want[32*f +: 32] !== rsp_tdata[32*f +: 32]) begin
                  $display("%0t: field %0d expected %h actual %h",
                           $time, f, want[32*f +: 32], rsp_tdata[32*f +: 32]);
                  fails++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else if (pending_q.size() > 0 || expected_q.size() > 0 || req_tvalid) begin
         quiet++;
         if (quiet >= WDOG_LIMIT) begin
            $display("** particle_stream_wall_bounce: FAILED **");
            $finish;
         end
      end
   end

   // sampled away from the rising edge so the sender's updates have settled
   task automatic wait_idle();
      @(negedge clock);
      while (pending_q.size() > 0 || req_tvalid || expected_q.size() > 0)
         @(negedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_WALL_MODE:  cfg_mode = val[1:0];
         REG_TIME_STEP:  cfg_step = longint'(val[19:0]);
         REG_TOP_HEIGHT: cfg_top = longint'(val[30:0]);
         REG_WALL_VEL_X: cfg_wvx = longint'($signed(val));
         REG_WALL_VEL_Y: cfg_wvy = longint'($signed(val));
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_particle(logic [191:0] d);
      stim_type s;
      s.particle = d;
      s.fixed = 0;
      s.result = '0;
      pending_q.insert(pending_q.size(), s);
   endtask

   function automatic logic [31:0] rand_word(int spread);
      case ($urandom_range(0, 6))
         0: return $urandom();
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return 32'h8000_0000 + $urandom_range(0, 3);
         3: return $urandom_range(0, 8);
         default: return 32'(int'($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   // z near the walls so that reflections happen often
   function automatic logic [31:0] rand_height();
      case ($urandom_range(0, 3))
         0: return 32'(cfg_top - $urandom_range(0, 32'h4_0000));
         1: return 32'(int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
         2: return 32'(cfg_top + $urandom_range(0, 32'h2_0000));
         default: return rand_word(32'h20_0000);
      endcase
   endfunction

   row_type rows[$];

   task automatic add_row(row_type x);
      rows.insert(rows.size(), x);
   endtask

   initial begin
      row_type r;
      stim_type s;
      logic [31:0] vz;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // after reset: at rest, both extremes saturating
      add_row('{MODE_OFF, '0, 1, '0});
      add_row('{MODE_OFF, {6{32'h7FFF_FFFF}}, 1, {6{32'h7FFF_FFFF}}});
      add_row('{MODE_OFF, {6{32'h8000_0000}}, 1, {6{32'h8000_0000}}});
      add_row('{MODE_OFF, pack6(32'h1_0000, 32'h2_0000, 32'h3_0000,
                                32'hFFFF_8000, 32'h4000, 32'h1), 0, '0});
      // no-slip: above top, zero vz, then below bottom after the top check
      add_row('{MODE_NOSLIP, pack6(32'h5_0000, 32'h5_0000, 32'h8_0000, 32'h1_0000,
                                   32'hFFFF_0000, 32'h0), 0, '0});
      add_row('{MODE_NOSLIP, pack6(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h2_0000,
                                   32'h3_0000, 32'h6_0000), 0, '0});
      add_row('{MODE_NOSLIP, pack6(32'h1_0000, 32'h0, 32'h1_0000, 32'h2_0000,
                                   32'h1_0000, 32'hFFFD_0000), 0, '0});
      add_row('{MODE_NOSLIP, {6{32'h7FFF_FFFF}}, 0, '0});
      add_row('{MODE_NOSLIP, {6{32'h8000_0000}}, 0, '0});
      add_row('{MODE_NOSLIP, pack6(32'h0, 32'h0, 32'h8000_0000, 32'h0,
                                   32'h0, 32'h0), 0, '0});
      // slip: mirror about the top, bounce on the bottom
      add_row('{MODE_SLIP, pack6(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h2_0000,
                                 32'h3_0000, 32'h6_0000), 0, '0});
      add_row('{MODE_SLIP, pack6(32'h1_0000, 32'h0, 32'h1_0000, 32'h2_0000,
                                 32'h1_0000, 32'hFFFD_0000), 0, '0});
      add_row('{MODE_SLIP, {6{32'h7FFF_FFFF}}, 0, '0});
      add_row('{MODE_SLIP, {6{32'h8000_0000}}, 0, '0});
      // unused mode behaves as no walls
      add_row('{MODE_UNUSED, pack6(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h2_0000,
                                   32'h3_0000, 32'hFFF0_0000), 0, '0});

      foreach (rows[k]) begin
         r = rows[k];
         if (r.mode != cfg_mode) begin
            wait_idle();
            if (cfg_mode == MODE_OFF) begin
               csr_write(REG_TOP_HEIGHT, 32'h8004_0000);   // top bit dropped
               csr_write(REG_WALL_VEL_X, 32'h0000_8000);
               csr_write(REG_WALL_VEL_Y, 32'hFFFF_4000);
            end
            csr_write(REG_WALL_MODE, {30'h3FFF_FFFF, r.mode});
         end
         s.particle = r.particle;
         s.fixed = r.fixed;
         s.result = r.result;
         pending_q.insert(pending_q.size(), s);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         csr_write(REG_WALL_MODE, (ph == 0) ? {30'h0, MODE_OFF} :
                   (ph == 1) ? {30'h0, MODE_UNUSED} :
                   (ph % 2 == 0) ? {30'h0, MODE_NOSLIP} : {30'h0, MODE_SLIP});
         csr_write(REG_TIME_STEP, (ph == 2) ? 32'h0 : (ph == 3) ? 32'hFFFF_FFFF :
                   (ph == 4) ? 32'h1_0000 : $urandom());
         csr_write(REG_TOP_HEIGHT, (ph == 5) ? 32'h7FFF_FFFF : (ph == 6) ? 32'h0 :
                   $urandom_range(1, 32'h40_0000));
         csr_write(REG_WALL_VEL_X, (ph == 4) ? 32'h7FFF_FFFF : (ph == 7) ? 32'h8000_0000 :
                   rand_word(32'h4_0000));
         csr_write(REG_WALL_VEL_Y, (ph == 4) ? 32'h8000_0000 : (ph == 7) ? 32'h7FFF_FFFF :
                   rand_word(32'h4_0000));
         for (logic [3:0] idx = 4'(REG_LAST) + 4'd1; idx < 4'd8; idx++)
            csr_write(idx[2:0], $urandom());
         for (int n = 0; n < PER_PHASE; n++) begin
            vz = rand_word(32'h8_0000);
            if ($urandom_range(0, 9) == 0) vz = 32'h0;
            queue_particle(pack6(rand_word(32'h100_0000), rand_word(32'h100_0000),
                                 rand_height(), rand_word(32'h8_0000),
                                 rand_word(32'h8_0000), vz));
            if (pending_q.size() > 64) begin
               while (pending_q.size() > 8) @(posedge clock);
            end
         end
      end

      wait_idle();
      if (fails == 0) begin
         $display("** particle_stream_wall_bounce: PASSED **");
      end else begin
         $display("** particle_stream_wall_bounce: FAILED **");
      end
      $finish;
   end

endmodule
